### src/cache_set_tag_store_lru_fifo_top_assert.svh
// assertion macros used by the tag store controller
`ifndef CACHE_SET_TAG_STORE_LRU_FIFO_TOP_ASSERT_SVH
`define CACHE_SET_TAG_STORE_LRU_FIFO_TOP_ASSERT_SVH

// checked only out of reset
`define CSTLF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define CSTLF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### src/cstlf_pkg.sv
`timescale 1ns / 1ps
package cstlf_pkg;

  localparam int unsigned WAYS_DEF = 8;

  // time written on insert, older than any stamp
  localparam logic [31:0] STAMP_NEVER = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    REQ_LOOKUP  = 3'd0,
    REQ_INSERT  = 3'd1,
    REQ_POP     = 3'd2,
    REQ_REPLACE = 3'd3,
    REQ_REMOVE  = 3'd4
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_POP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] stamp;
  } entry_t;

  typedef struct packed {
    logic        found;
    logic        out_valid;
    logic [31:0] out_tag;
    logic        full_error;
    logic [3:0]  entry_count;
  } result_t;

endpackage

### src/cstlf_mem.sv
`timescale 1ns / 1ps
module cstlf_mem #(
  parameter int unsigned WAYS = cstlf_pkg::WAYS_DEF,
  localparam int unsigned AW = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output cstlf_pkg::entry_t rd_data_o,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  cstlf_pkg::entry_t wr_data_i
);
  import cstlf_pkg::*;

  entry_t mem_q [WAYS];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### src/cstlf_ctrl.sv
`timescale 1ns / 1ps
module cstlf_ctrl #(
  parameter int unsigned WAYS = cstlf_pkg::WAYS_DEF,
  localparam int unsigned AW = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  cstlf_pkg::req_e    req_i,
  input  logic [31:0]        tag_i,
  input  logic [30:0]        stamp_i,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output cstlf_pkg::result_t res_o,
  output logic               mem_rd_en_o,
  output logic [AW-1:0]      mem_rd_addr_o,
  output logic               mem_wr_en_o,
  output logic [AW-1:0]      mem_wr_addr_o,
  output cstlf_pkg::entry_t  mem_wr_data_o,
  input  cstlf_pkg::entry_t  mem_rd_data_i
);
  import cstlf_pkg::*;

  `include "cache_set_tag_store_lru_fifo_top_assert.svh"

  localparam int unsigned CNT_W   = $clog2(WAYS + 1);
  localparam int unsigned CNT_X_W = (CNT_W > 4) ? CNT_W : 4;

  state_e state_q, state_d;
  req_e   req_q, req_d;
  logic [31:0]      tag_q, tag_d;
  logic [30:0]      stamp_q, stamp_d;
  logic [AW-1:0]    head_q, head_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;        // next logical entry to read
  logic [CNT_W-1:0] rd_idx_q, rd_idx_d;  // logical entry now on the read port
  logic [CNT_W-1:0] best_idx_q, best_idx_d;
  logic [31:0]      best_stamp_q, best_stamp_d;
  logic [31:0]      best_tag_q, best_tag_d;
  logic             r_found_q, r_found_d;
  logic             r_oval_q, r_oval_d;
  logic [31:0]      r_otag_q, r_otag_d;
  logic             r_full_q, r_full_d;

  logic             accept;
  logic             empty;
  logic             full;
  logic             last;
  logic             cur_match;
  logic             cur_better;
  logic [CNT_W-1:0] vic_idx;
  logic [31:0]      vic_tag;
  logic [CNT_X_W-1:0] cnt_ext;

  // logical position from the front to physical slot
  function automatic logic [AW-1:0] phys(input logic [CNT_W-1:0] pos,
                                         input logic [AW-1:0] head);
    logic [AW:0] sum;
    sum = {1'b0, head} + (AW+1)'(pos);
    if (sum >= (AW+1)'(WAYS)) begin
      sum = sum - (AW+1)'(WAYS);
    end
    return sum[AW-1:0];
  endfunction

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign empty      = (count_q == '0);
  assign full       = (count_q == CNT_W'(WAYS));
  assign last       = (rd_idx_q == count_q - CNT_W'(1));
  assign cur_match  = (mem_rd_data_i.tag == tag_q);
  assign cur_better = (rd_idx_q == '0) ||
                      ($signed(mem_rd_data_i.stamp) < $signed(best_stamp_q));
  assign vic_idx    = cur_better ? rd_idx_q : best_idx_q;
  assign vic_tag    = cur_better ? mem_rd_data_i.tag : best_tag_q;
  assign cnt_ext    = CNT_X_W'(count_q);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_i) inside
            REQ_LOOKUP, REQ_REPLACE, REQ_REMOVE: state_d = empty ? ST_DONE : ST_SCAN;
            REQ_POP:                             state_d = empty ? ST_DONE : ST_POP;
            default:                             state_d = ST_DONE;
          endcase
        end
      end
      ST_SCAN: begin
        unique case (req_q) inside
          REQ_LOOKUP: begin
            if (cur_match || last) state_d = ST_DONE;
          end
          REQ_REMOVE: begin
            if (cur_match) state_d = last ? ST_DONE : ST_SHIFT;
            else if (last) state_d = ST_DONE;
          end
          default: begin
            if (last) state_d = ST_DONE;
          end
        endcase
      end
      ST_SHIFT: begin
        if (last) state_d = ST_DONE;
      end
      ST_POP:  state_d = ST_DONE;
      ST_DONE: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and memory port control
  always_comb begin
    in_ready_o          = (state_q == ST_IDLE);
    res_valid_o         = (state_q == ST_DONE);
    res_o.found         = r_found_q;
    res_o.out_valid     = r_oval_q;
    res_o.out_tag       = r_otag_q;
    res_o.full_error    = r_full_q;
    res_o.entry_count   = cnt_ext[3:0];
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = phys(idx_q, head_q);
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = phys(rd_idx_q, head_q);
    mem_wr_data_o = '{tag: tag_q, stamp: {1'b0, stamp_q}};
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_i) inside
            REQ_LOOKUP, REQ_REPLACE, REQ_REMOVE, REQ_POP: begin
              mem_rd_en_o   = !empty;
              mem_rd_addr_o = head_q;
            end
            REQ_INSERT: begin
              mem_wr_en_o   = !full;
              mem_wr_addr_o = phys(count_q, head_q);
              mem_wr_data_o = '{tag: tag_i, stamp: STAMP_NEVER};
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        unique case (req_q) inside
          REQ_LOOKUP: begin
            // stamp the first hit in place
            mem_wr_en_o = cur_match;
            mem_rd_en_o = !cur_match && !last;
          end
          REQ_REMOVE: begin
            // keep reading past a hit: the next entry feeds the shift
            mem_rd_en_o = !last;
          end
          default: begin
            mem_rd_en_o   = !last;
            mem_wr_en_o   = last;
            mem_wr_addr_o = phys(vic_idx, head_q);
          end
        endcase
      end
      ST_SHIFT: begin
        mem_rd_en_o   = !last;
        mem_wr_en_o   = 1'b1;
        mem_wr_addr_o = phys(rd_idx_q - CNT_W'(1), head_q);
        mem_wr_data_o = mem_rd_data_i;
      end
      default: ;
    endcase
  end

  // datapath next values
  always_comb begin
    req_d        = req_q;
    tag_d        = tag_q;
    stamp_d      = stamp_q;
    head_d       = head_q;
    count_d      = count_q;
    idx_d        = idx_q;
    rd_idx_d     = rd_idx_q;
    best_idx_d   = best_idx_q;
    best_stamp_d = best_stamp_q;
    best_tag_d   = best_tag_q;
    r_found_d    = r_found_q;
    r_oval_d     = r_oval_q;
    r_otag_d     = r_otag_q;
    r_full_d     = r_full_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          req_d     = req_i;
          tag_d     = tag_i;
          stamp_d   = stamp_i;
          idx_d     = CNT_W'(1);
          rd_idx_d  = '0;
          r_found_d = 1'b0;
          r_oval_d  = 1'b0;
          r_otag_d  = '0;
          r_full_d  = 1'b0;
          if (req_i == REQ_INSERT) begin
            if (full) r_full_d = 1'b1;
            else      count_d  = count_q + CNT_W'(1);
          end
        end
      end
      ST_SCAN: begin
        if (mem_rd_en_o) begin
          idx_d    = idx_q + CNT_W'(1);
          rd_idx_d = idx_q;
        end
        case (req_q)
          REQ_LOOKUP: begin
            if (cur_match) r_found_d = 1'b1;
          end
          REQ_REMOVE: begin
            if (cur_match) begin
              r_found_d = 1'b1;
              if (last) count_d = count_q - CNT_W'(1);
            end
          end
          default: begin
            if (cur_better) begin
              best_idx_d   = rd_idx_q;
              best_stamp_d = mem_rd_data_i.stamp;
              best_tag_d   = mem_rd_data_i.tag;
            end
            if (last) begin
              r_found_d = 1'b1;
              r_otag_d  = vic_tag;
            end
          end
        endcase
      end
      ST_SHIFT: begin
        if (mem_rd_en_o) begin
          idx_d    = idx_q + CNT_W'(1);
          rd_idx_d = idx_q;
        end
        if (last) count_d = count_q - CNT_W'(1);
      end
      ST_POP: begin
        r_oval_d = 1'b1;
        r_otag_d = mem_rd_data_i.tag;
        head_d   = phys(CNT_W'(1), head_q);
        count_d  = count_q - CNT_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    tag_q        <= tag_d;
    stamp_q      <= stamp_d;
    idx_q        <= idx_d;
    rd_idx_q     <= rd_idx_d;
    best_idx_q   <= best_idx_d;
    best_stamp_q <= best_stamp_d;
    best_tag_q   <= best_tag_d;
    r_found_q    <= r_found_d;
    r_oval_q     <= r_oval_d;
    r_otag_q     <= r_otag_d;
    r_full_q     <= r_full_d;
  end

  `CSTLF_ASSERT(a_rw_apart, (mem_rd_en_o && mem_wr_en_o) |-> (mem_rd_addr_o != mem_wr_addr_o), "read and write on the same slot")
  `CSTLF_ASSERT(a_cnt_step, !$stable(count_q) |-> ((count_q == $past(count_q) + CNT_W'(1)) || (count_q == $past(count_q) - CNT_W'(1))), "entry count jumped")
  `CSTLF_ASSERT_ALWAYS(a_cnt_max, (!rst_ni || (count_q <= CNT_W'(WAYS))), "entry count above capacity")
  `CSTLF_ASSERT(a_done_quiet, (state_q == ST_DONE) |-> (!mem_rd_en_o && !mem_wr_en_o), "memory access while result pending")

endmodule

### src/cache_set_tag_store_lru_fifo_top.sv
`timescale 1ns / 1ps
// sequence: insert, pop on empty and unused codes go from the accepted word straight to the result;
//   pop passes the pop state; lookup, replace and remove read k entries (0 when empty, else 1 .. entry count)
// flow: one word in the controller at a time; the next word is taken the cycle after its result is registered
//   in the output register; scans are set by the single memory read port
// reset (rst_ni low, asynchronous): store empty, head at slot 0, no result pending;
//   memory contents are not cleared, entries beyond the count are never read
module cache_set_tag_store_lru_fifo_top #(
  parameter int unsigned WAYS = cstlf_pkg::WAYS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // tag [31:0], time_stamp [62:32], zero [63]
  input  logic [2:0]  s_axis_tuser,   // req_type [2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata    // found [0], out_valid [1], out_tag [33:2],
                                      // full_error [34], entry_count [38:35], zero [39]
);
  import cstlf_pkg::*;

  localparam int unsigned AW = (WAYS > 1) ? $clog2(WAYS) : 1;

  // controller to memory, and read data back
  logic          mem_rd_en;
  logic [AW-1:0] mem_rd_addr;
  logic          mem_wr_en;
  logic [AW-1:0] mem_wr_addr;
  entry_t        mem_wr_data;
  entry_t        mem_rd_data;

  // controller result and the output register behind it
  logic    res_valid;
  logic    res_ready;
  result_t res;
  logic    m_valid_q, m_valid_d;
  result_t m_data_q, m_data_d;

  // sequencer: inserts, pops, scans, shifts and stamps entries through the memory
  cstlf_ctrl #(
    .WAYS (WAYS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .req_i         (req_e'(s_axis_tuser)),
    .tag_i         (s_axis_tdata[31:0]),
    .stamp_i       (s_axis_tdata[62:32]),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_data_i (mem_rd_data)
  );

  // entries kept as a ring from the head slot, tag and time side by side
  cstlf_mem #(
    .WAYS (WAYS)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data)
  );

  // output register: the controller hands over once the slot is free or draining
  assign res_ready = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    if (res_ready) begin
      m_valid_d = res_valid;
      if (res_valid) m_data_d = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, m_data_q.entry_count, m_data_q.full_error,
                          m_data_q.out_tag, m_data_q.out_valid, m_data_q.found};

endmodule
